@@ sv/rrdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrdc_pkg
// Shared constants and types for the route request duplicate cache.
// ----------------------------------------------------------------------------
package rrdc_pkg;

  localparam int unsigned CACHE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(CACHE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CACHE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CACHE_DEPTH);

  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd30;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_SWEEP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SWEEP = 2'd2;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             finish;
  } dp_cmd_t;

endpackage

@@ sv/route_request_duplicate_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_request_duplicate_cache
// Cache of recently seen route request ids with duplicate detection,
// oldest-entry replacement and timeout sweep.
// ----------------------------------------------------------------------------
// usage
//   input word (cmd, route_id, source_node, now_time) is taken when
//   in_valid is high and in_stall low; cmd 0 adds a request, cmd 1 sweeps
//   expired entries at now_time; one result word (status, slot_index,
//   replaced_oldest) per input word, taken when out_valid is high and
//   out_stall low; request_timeout is written through cfg_wr_en /
//   cfg_wr_data only while idle, by the user: the block does not enforce it
// timing
//   one slot of the entry memory is read per cycle, so out_valid rises
//   after the walk over all CACHE_DEPTH slots, the drain state and the
//   finish state, once the output register is free; one word is in work
//   at a time, a new word is taken the cycle after the result is loaded
// reset
//   rst clears the active bits, the fill count and any pending result and
//   restores request_timeout to 30
// stall
//   a stalled result holds; a finished walk waits until the output
//   register is free, and in_stall stays high meanwhile
// ----------------------------------------------------------------------------
module route_request_duplicate_cache
  import rrdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [DATA_W-1:0]   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [DATA_W-1:0]   route_id,
  input  logic [DATA_W-1:0]   source_node,
  input  logic [DATA_W-1:0]   now_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_index,
  output logic                replaced_oldest
);

  dp_cmd_t dp_cmd;

  rrdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd)
  );

  rrdc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (cmd),
    .in_route_id     (route_id),
    .in_source_node  (source_node),
    .in_now_time     (now_time),
    .status          (status),
    .slot_index      (slot_index),
    .replaced_oldest (replaced_oldest)
  );

endmodule

@@ sv/rrdc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrdc_ctrl
// Sequencer: takes a word, walks every slot once, then hands the result to
// the output register.
// ----------------------------------------------------------------------------
module rrdc_ctrl
  import rrdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    DRAIN,
    FINISH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] walk_idx;
  logic             finish;

  assign finish   = (state == FINISH) && (!out_valid || !out_stall);
  assign in_stall = (state != IDLE);

  assign cmd.load    = (state == IDLE) && in_valid;
  assign cmd.rd_en   = (state == WALK);
  assign cmd.rd_addr = walk_idx;
  assign cmd.finish  = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      walk_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            walk_idx <= '0;
            state    <= WALK;
          end
        end
        WALK: begin
          walk_idx <= walk_idx + 1'b1;
          if (walk_idx == LAST_IDX) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= FINISH;
        end
        FINISH: begin
          if (finish) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == WALK && walk_idx == '0))
    else $error("accepted word did not start a walk");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == FINISH)
    else $error("result raised outside finish");

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && out_valid && out_stall) |=> (state == FINISH))
    else $error("finish overwrote a pending result");

endmodule

@@ sv/rrdc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrdc_datapath
// Entry memories, active bits, fill count, per-slot compare and the output
// register.
// ----------------------------------------------------------------------------
module rrdc_datapath
  import rrdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  input  logic                cfg_wr_en,
  input  logic [DATA_W-1:0]   cfg_wr_data,
  input  logic                in_cmd,
  input  logic [DATA_W-1:0]   in_route_id,
  input  logic [DATA_W-1:0]   in_source_node,
  input  logic [DATA_W-1:0]   in_now_time,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_index,
  output logic                replaced_oldest
);

  logic [DATA_W-1:0] entry_request    [CACHE_DEPTH];
  logic [DATA_W-1:0] entry_originator [CACHE_DEPTH];
  logic [DATA_W-1:0] entry_stamp      [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] entry_active;
  logic [CNT_W-1:0]       fill_count;

  logic [DATA_W-1:0] request_timeout;

  logic              op;
  logic [DATA_W-1:0] rid;
  logic [DATA_W-1:0] orig;
  logic [DATA_W-1:0] now;

  logic [DATA_W-1:0] rd_request;
  logic [DATA_W-1:0] rd_stamp;
  logic              eval_vld;
  logic [IDX_W-1:0]  eval_idx;

  logic              dup;
  logic [DATA_W-1:0] best_stamp;
  logic [IDX_W-1:0]  best_idx;

  logic              in_range;
  logic              full;
  logic              do_write;
  logic [IDX_W-1:0]  wr_slot;
  logic [DATA_W-1:0] age;

  assign in_range = ({1'b0, eval_idx} < fill_count);
  assign full     = (fill_count == FULL_COUNT);
  assign do_write = cmd.finish && (op == CMD_ADD) && !dup;
  assign wr_slot  = full ? best_idx : fill_count[IDX_W-1:0];
  assign age      = now - rd_stamp;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      request_timeout <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      request_timeout <= cfg_wr_data;
    end
  end

  // word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_cmd;
      rid  <= in_route_id;
      orig <= in_source_node;
      now  <= in_now_time;
    end
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (do_write) begin
      entry_request[wr_slot]    <= rid;
      entry_originator[wr_slot] <= orig;
      entry_stamp[wr_slot]      <= now;
    end
    if (cmd.rd_en) begin
      rd_request <= entry_request[cmd.rd_addr];
      rd_stamp   <= entry_stamp[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_vld <= 1'b0;
    end else begin
      eval_vld <= cmd.rd_en;
    end
    eval_idx <= cmd.rd_addr;
  end

  // per-slot evaluation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dup <= 1'b0;
    end else if (eval_vld) begin
      if (op == CMD_ADD && in_range && entry_active[eval_idx] && rd_request == rid) begin
        dup <= 1'b1;
      end
      if (eval_idx == '0 || rd_stamp < best_stamp) begin
        best_stamp <= rd_stamp;
        best_idx   <= eval_idx;
      end
    end
  end

  // active bits and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_active <= '0;
      fill_count   <= '0;
    end else begin
      if (eval_vld && op == CMD_SWEEP && in_range && age > request_timeout) begin
        entry_active[eval_idx] <= 1'b0;
      end
      if (do_write) begin
        entry_active[wr_slot] <= 1'b1;
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (op == CMD_SWEEP) begin
        status          <= ST_SWEEP;
        slot_index      <= '0;
        replaced_oldest <= 1'b0;
      end else if (dup) begin
        status          <= ST_DUP;
        slot_index      <= '0;
        replaced_oldest <= 1'b0;
      end else begin
        status          <= ST_ADDED;
        slot_index      <= SLOT_W'(wr_slot);
        replaced_oldest <= full;
      end
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL_COUNT)
    else $error("fill count beyond depth");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> fill_count >= $past(fill_count))
    else $error("fill count shrank");

  a_sweep_no_write: assert property (@(posedge clk) disable iff (rst)
    (op == CMD_SWEEP) |-> !do_write)
    else $error("sweep wrote an entry");

endmodule

@@ test/tb_route_request_duplicate_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_route_request_duplicate_cache
// Self-checking bench for the route request duplicate cache. A queue of
// directed and random words (adds with reused and fresh ids, sweeps at moving
// and wrapped times) feeds a clocked driver; a clocked monitor compares every
// result word with a cycle-free model of the cache. The timeout register is
// rewritten between phases once the block has drained, and both sides idle in
// random bursts except in the second and the final random phase.
// ----------------------------------------------------------------------------
module tb_route_request_duplicate_cache;
  import rrdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 120;
  localparam int unsigned POOL_SIZE   = 24;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] route_id;
    logic [DATA_W-1:0] source_node;
    logic [DATA_W-1:0] now_time;
  } route_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                replaced;
  } cache_status_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [DATA_W-1:0]   cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_ADD;
  logic [DATA_W-1:0]   route_id = '0;
  logic [DATA_W-1:0]   source_node = '0;
  logic [DATA_W-1:0]   now_time = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic                replaced_oldest;

  route_request_duplicate_cache dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .route_id        (route_id),
    .source_node     (source_node),
    .now_time        (now_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .slot_index      (slot_index),
    .replaced_oldest (replaced_oldest)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the cache contents
  logic [DATA_W-1:0] cached_request [CACHE_DEPTH];
  logic [DATA_W-1:0] cached_origin [CACHE_DEPTH];
  logic [DATA_W-1:0] cached_stamp [CACHE_DEPTH];
  logic              cached_active [CACHE_DEPTH];
  int unsigned       slots_filled = 0;
  logic [DATA_W-1:0] timeout_value = TIMEOUT_RESET;

  route_word_t   requests_to_send[$];
  cache_status_t status_due[$];
  route_word_t   in_flight;
  int unsigned   words_queued = 0;
  int unsigned   words_accepted = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;
  int unsigned   send_gap = 0;
  int unsigned   stall_left = 0;
  logic          idle_bursts = 1'b1;
  logic [DATA_W-1:0] id_pool [POOL_SIZE];
  logic [DATA_W-1:0] clock_now;

  function automatic cache_status_t apply_to_cache(route_word_t w);
    cache_status_t r;
    logic          hit;
    int unsigned   victim;
    r = '0;
    hit = 1'b0;
    if (w.cmd == CMD_SWEEP) begin
      for (int i = 0; i < slots_filled; i++)
        if (DATA_W'(w.now_time - cached_stamp[i]) > timeout_value)
          cached_active[i] = 1'b0;
      r.status = ST_SWEEP;
    end else begin
      for (int i = 0; i < slots_filled; i++)
        if (cached_active[i] && cached_request[i] == w.route_id)
          hit = 1'b1;
      if (hit) begin
        r.status = ST_DUP;
      end else begin
        if (slots_filled == CACHE_DEPTH) begin
          victim = 0;
          for (int i = 1; i < CACHE_DEPTH; i++)
            if (cached_stamp[i] < cached_stamp[victim])
              victim = i;
          r.replaced = 1'b1;
        end else begin
          victim = slots_filled;
          slots_filled++;
        end
        cached_request[victim] = w.route_id;
        cached_origin[victim]  = w.source_node;
        cached_stamp[victim]   = w.now_time;
        cached_active[victim]  = 1'b1;
        r.slot   = SLOT_W'(victim);
        r.status = ST_ADDED;
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        status_due.push_back(apply_to_cache(in_flight));
        words_accepted++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (requests_to_send.size() > 0) begin
        in_flight = requests_to_send.pop_front();
        cmd         <= in_flight.cmd;
        route_id    <= in_flight.route_id;
        source_node <= in_flight.source_node;
        now_time    <= in_flight.now_time;
        in_valid    <= 1'b1;
        if (idle_bursts && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cache_status_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: status %0d slot %0d replaced %0b",
                     status, slot_index, replaced_oldest);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          if (status !== want.status || slot_index !== want.slot ||
              replaced_oldest !== want.replaced) begin
            if (mismatches < 10)
              $display("result mismatch: expected status %0d slot %0d replaced %0b, got %0d %0d %0b",
                       want.status, want.slot, want.replaced,
                       status, slot_index, replaced_oldest);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_word(input logic c, input logic [DATA_W-1:0] id,
                           input logic [DATA_W-1:0] orig, input logic [DATA_W-1:0] t);
    route_word_t w;
    w.cmd         = c;
    w.route_id    = id;
    w.source_node = orig;
    w.now_time    = t;
    requests_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (words_accepted != words_queued || status_due.size() != 0);
  endtask

  task automatic write_timeout(input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    timeout_value = value;
  endtask

  // adds from a small id pool near a moving clock, mixed with sweeps
  task automatic queue_random_words(input int unsigned count);
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] t;
    repeat (count) begin
      clock_now = clock_now + $urandom_range(0, 8);
      t = ($urandom_range(0, 15) == 0) ? $urandom : clock_now;
      if ($urandom_range(0, 4) == 0) begin
        push_word(CMD_SWEEP, $urandom, $urandom, t + $urandom_range(0, 40));
      end else begin
        id = ($urandom_range(0, 9) < 6) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : $urandom;
        push_word(CMD_ADD, id, $urandom, t);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++)
      id_pool[i] = $urandom;
    clock_now = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, inactive match, fill, ties, wrapped sweep
    push_word(CMD_ADD, '0, '0, '0);
    push_word(CMD_ADD, '1, '1, '1);
    push_word(CMD_ADD, '0, 32'h1234_5678, 32'd5);
    push_word(CMD_SWEEP, '0, '0, 32'd20);
    push_word(CMD_SWEEP, '1, '1, 32'd31);
    push_word(CMD_ADD, '0, 32'hAAAA_5555, 32'd40);
    push_word(CMD_ADD, '1, 32'h5555_AAAA, 32'd40);
    for (int k = 0; k < 12; k++)
      push_word(CMD_ADD, 32'h1000_0000 + k, $urandom, (k < 4) ? 32'd7 : 32'd50 + k);
    push_word(CMD_ADD, '0, $urandom, 32'd60);
    push_word(CMD_ADD, 32'd2000, $urandom, 32'd60);
    push_word(CMD_ADD, 32'd2001, $urandom, 32'd60);
    push_word(CMD_SWEEP, '0, '0, '1);
    push_word(CMD_ADD, '0, $urandom, 32'd1);
    wait_drained();

    write_timeout('0);
    queue_random_words(PHASE_WORDS);
    wait_drained();

    idle_bursts = 1'b0;
    write_timeout('1);
    queue_random_words(PHASE_WORDS);
    wait_drained();

    idle_bursts = 1'b1;
    write_timeout($urandom_range(5, 60));
    queue_random_words(PHASE_WORDS);
    wait_drained();

    idle_bursts = 1'b0;
    write_timeout($urandom_range(20, 300));
    queue_random_words(PHASE_WORDS + 20);
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ route_request_duplicate_cache.f @@
sv/rrdc_pkg.sv
sv/rrdc_ctrl.sv
sv/rrdc_datapath.sv
sv/route_request_duplicate_cache.sv
test/tb_route_request_duplicate_cache.sv
